>>> rtl/chac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chac_pkg: shared types and constants of the closest hit alpha compositor
// Opcodes, sequencer states, multiplier widths and reciprocal constants.
// ----------------------------------------------------------------------------
package chac_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_SETEND = 2'd1,
    OP_HIT    = 2'd2,
    OP_FINISH = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIR,
    ST_KEEP,
    ST_KMUL,
    ST_KLATCH,
    ST_CHAN,
    ST_TMUL,
    ST_TDIV,
    ST_TDONE,
    ST_DONE
  } state_e;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [7:0]  ALPHA_FULL = 8'd255;
  localparam logic [15:0] K_FULL     = 16'd65025;

  // floor(x / 65025) = (x * RECIP_K) >> SHIFT_K, exact for x < 255 * 65025 + 1
  localparam logic [MUL_B_W-1:0] RECIP_K = 25'd16909061;
  localparam int unsigned        SHIFT_K = 40;
  // floor(x / 255) = (x * RECIP_A) >> SHIFT_A, exact for x <= 65025
  localparam logic [MUL_B_W-1:0] RECIP_A = 25'd65794;
  localparam int unsigned        SHIFT_A = 24;

  // channel phases of the finish sequence and the last axis of the hit compare
  localparam logic [2:0] PH_LAST = 3'd4;
  localparam logic [1:0] CH_LAST = 2'd2;
  localparam logic [1:0] AX_LAST = 2'd2;

endpackage
`default_nettype wire

>>> rtl/chac_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chac_mul: shared registered multiplier
// Unsigned 24 x 25 bit product, registered when enabled.
// ----------------------------------------------------------------------------
module chac_mul
  import chac_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [MUL_A_W-1:0] a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic      [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/closest_hit_alpha_compositor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_hit_alpha_compositor: per-ray closest hit and front-to-back blend
// Keeps the closest acceptable hit of a ray and blends it into the colour
// accumulator on finish, one shared multiplier doing all products.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o | opcode, position, hit distance/colour
//  out     | out_valid_o/out_ready_i | accumulated colour, alpha, escaping
//
// One beat in, one beat out. An offered hit compares one axis a cycle;
// finish runs through the single multiplier: 2 products and 2 reciprocal
// products per colour channel plus 3 for the alpha terms.
// A finished result waits in the output register; the next beat is taken
// meanwhile. Reset gives the ray state its idle values, no clearing pass.
// ----------------------------------------------------------------------------
module closest_hit_alpha_compositor
  import chac_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [31:0]        hit_distance_i,
  input  wire logic [7:0]         hit_red_i,
  input  wire logic [7:0]         hit_green_i,
  input  wire logic [7:0]         hit_blue_i,
  input  wire logic [7:0]         hit_alpha_i,
  input  wire logic               ignore_direction_i,
  input  wire logic               move_origin_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              acc_red_o,
  output logic [7:0]              acc_green_o,
  output logic [7:0]              acc_blue_o,
  output logic [7:0]              remaining_alpha_o,
  output logic                    escaping_o
);

  function automatic logic above(input logic [COORD_BITS-1:0] a,
                                 input logic [COORD_BITS-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  // sequencer
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire, out_load;

  // captured beat
  opcode_e               op_q;
  logic [COORD_BITS-1:0] pos_q [3];
  logic [31:0]           dist_q;
  logic [7:0]            hc_q [3];
  logic [7:0]            ha_q;
  logic                  ign_q, mov_q;

  // ray state
  logic [COORD_BITS-1:0] org_q  [3];
  logic [COORD_BITS-1:0] end_q  [3];
  logic [COORD_BITS-1:0] kpos_q [3];
  logic [31:0]           kd_q;
  logic [7:0]            kc_q [3];
  logic [7:0]            ka_q;
  logic [7:0]            acc_q [3];
  logic [7:0]            ta_q;
  logic                  esc_q;

  // sequencing and scratch
  logic [1:0]  ax_q, ch_q;
  logic [2:0]  ph_q;
  logic        dir_ok_q;
  logic [15:0] k_q;
  logic [7:0]  q1_q;

  // shared multiplier
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [7:0] quot_k, quot_a;
  logic [8:0] chan_sum;
  logic       keep_hit;

  chac_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign quot_k   = 8'(mul_p >> SHIFT_K);
  assign quot_a   = 8'(mul_p >> SHIFT_A);
  assign chan_sum = {1'b0, q1_q} + {1'b0, quot_k};
  assign keep_hit = (ign_q || dir_ok_q) && (dist_q <= kd_q) && (ha_q != 8'd0);
  assign in_fire  = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (op_q)
          OP_HIT:    state_d = ST_DIR;
          OP_FINISH: state_d = ST_KMUL;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_DIR:      if (ax_q == AX_LAST) state_d = ST_KEEP;
      ST_KEEP:     state_d = ST_DONE;
      ST_KMUL:     state_d = ST_KLATCH;
      ST_KLATCH:   state_d = ST_CHAN;
      ST_CHAN:     if (ph_q == PH_LAST && ch_q == CH_LAST) state_d = ST_TMUL;
      ST_TMUL:     state_d = ST_TDIV;
      ST_TDIV:     state_d = ST_TDONE;
      ST_TDONE:    state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_KMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ka_q);
        mul_b  = MUL_B_W'(ta_q);
      end
      ST_CHAN: begin
        mul_en = (ph_q != PH_LAST);
        case (ph_q)
          3'd0: begin
            mul_a = MUL_A_W'(kc_q[ch_q]);
            mul_b = MUL_B_W'(k_q);
          end
          3'd2: begin
            mul_a = MUL_A_W'(acc_q[ch_q]);
            mul_b = MUL_B_W'(K_FULL - k_q);
          end
          default: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = RECIP_K;
          end
        endcase
      end
      ST_TMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ta_q);
        mul_b  = MUL_B_W'(ALPHA_FULL - ka_q);
      end
      ST_TDIV: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MUL_A_W-1:0];
        mul_b  = RECIP_A;
      end
      ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // beat capture, scratch and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= opcode_e'(opcode_i);
      pos_q[0] <= COORD_BITS'($unsigned(pos_x_i));
      pos_q[1] <= COORD_BITS'($unsigned(pos_y_i));
      pos_q[2] <= COORD_BITS'($unsigned(pos_z_i));
      dist_q   <= hit_distance_i;
      hc_q[0]  <= hit_red_i;
      hc_q[1]  <= hit_green_i;
      hc_q[2]  <= hit_blue_i;
      ha_q     <= hit_alpha_i;
      ign_q    <= ignore_direction_i;
      mov_q    <= move_origin_i;
    end
    if (state_q == ST_KLATCH) k_q <= mul_p[15:0];
    if (state_q == ST_CHAN && ph_q == 3'd2) q1_q <= quot_k;
    if (out_load) begin
      acc_red_o         <= acc_q[0];
      acc_green_o       <= acc_q[1];
      acc_blue_o        <= acc_q[2];
      remaining_alpha_o <= ta_q;
      escaping_o        <= esc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ax_q        <= '0;
      ch_q        <= '0;
      ph_q        <= '0;
      dir_ok_q    <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        org_q[i]  <= '0;
        end_q[i]  <= '0;
        kpos_q[i] <= '0;
        kc_q[i]   <= '0;
        acc_q[i]  <= '0;
      end
      kd_q  <= '1;
      ka_q  <= ALPHA_FULL;
      ta_q  <= ALPHA_FULL;
      esc_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          ax_q     <= '0;
          ch_q     <= '0;
          ph_q     <= '0;
          dir_ok_q <= 1'b1;
        end
        ST_DISPATCH: begin
          case (op_q)
            OP_BEGIN: begin
              for (int i = 0; i < 3; i++) begin
                org_q[i]  <= pos_q[i];
                kpos_q[i] <= pos_q[i];
                acc_q[i]  <= '0;
                kc_q[i]   <= '0;
              end
              ta_q  <= ALPHA_FULL;
              ka_q  <= ALPHA_FULL;
              kd_q  <= '1;
              esc_q <= 1'b1;
            end
            OP_SETEND: begin
              for (int i = 0; i < 3; i++) end_q[i] <= pos_q[i];
            end
            OP_FINISH: begin
              if (mov_q) begin
                for (int i = 0; i < 3; i++) org_q[i] <= kpos_q[i];
              end
            end
            default: ;
          endcase
        end
        ST_DIR: begin
          if (above(end_q[ax_q], org_q[ax_q]) != above(pos_q[ax_q], org_q[ax_q])) begin
            dir_ok_q <= 1'b0;
          end
          ax_q <= ax_q + 2'd1;
        end
        ST_KEEP: begin
          if (keep_hit) begin
            kd_q <= dist_q;
            ka_q <= ha_q;
            for (int i = 0; i < 3; i++) begin
              kpos_q[i] <= pos_q[i];
              kc_q[i]   <= hc_q[i];
            end
          end
        end
        ST_CHAN: begin
          if (ph_q == PH_LAST) begin
            acc_q[ch_q] <= chan_sum[8] ? ALPHA_FULL : chan_sum[7:0];
            ph_q        <= '0;
            ch_q        <= ch_q + 2'd1;
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_TDONE: begin
          ta_q <= quot_a;
          if (quot_a == 8'd0) esc_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/chac_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chac_checker: port-level checks of the compositor
// Watches the handshakes and result beats at the top-level ports.
// ----------------------------------------------------------------------------
module chac_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] acc_red_o,
  input wire logic [7:0] acc_green_o,
  input wire logic [7:0] acc_blue_o,
  input wire logic [7:0] remaining_alpha_o,
  input wire logic       escaping_o
);

  // one beat at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after a beat");

  // escape flag tracks a nonzero transmittance
  a_escape_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (escaping_o == (remaining_alpha_o != 8'd0)))
    else $error("escaping disagrees with remaining alpha");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(acc_red_o)
      && $stable(acc_green_o) && $stable(acc_blue_o)
      && $stable(remaining_alpha_o) && $stable(escaping_o)))
    else $error("result beat changed while stalled");

  // escape only clears once no light is left
  a_opaque_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !escaping_o) |-> (remaining_alpha_o == 8'd0))
    else $error("escape cleared with light remaining");

endmodule

bind closest_hit_alpha_compositor chac_checker u_chac_checker (.*);
`default_nettype wire
